// ===== design/lcd_color_correction_rgb555_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the RGB555 LCD colour correction block.
// ----------------------------------------------------------------------------
`ifndef LCD_COLOR_CORRECTION_RGB555_ASSERT_SVH
`define LCD_COLOR_CORRECTION_RGB555_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define LCCR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lccr555 check failed");

// Next-cycle implication, switched off while reset is asserted.
`define LCCR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lccr555 check failed");

// Next-cycle implication that is also checked across reset.
`define LCCR_ASSERT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lccr555 check failed");

`endif

// ===== design/lccr555_pkg.sv =====
// ----------------------------------------------------------------------------
// lccr555_pkg
// Shared constants, tables and helper types for the RGB555 colour corrector.
// ----------------------------------------------------------------------------
`default_nettype none

package lccr555_pkg;

  // Number of register stages from input to output.
  localparam int NSTG = 10;

  // Widest linearisation table entry (fraction bits at their maximum, plus one).
  localparam int LIN_W_MAX = 25;

  // Width of the value that enters the square root.
  localparam int ISQ_W = 17;

  // 31 to the fifth power.
  localparam logic [79:0] DEN5 = 80'd28629151;

  // Brightness gain after reset, roughly 0.93 in Q0.16.
  localparam logic [15:0] LUM_RESET = 16'd60948;

  // Mixing matrix, Q2.14, one row per output channel (red, green, blue).
  localparam logic signed [15:0] MIX_COEF [3][3] = '{
    '{16'sd13107, 16'sd4506, -16'sd1229},
    '{16'sd2212,  16'sd10486, 16'sd3686},
    '{16'sd3195,  16'sd2540,  16'sd10650}
  };

  typedef logic [LIN_W_MAX-1:0] lin_rom_t [32];
  typedef logic [4:0]           five_rom_t [256];

  // floor((k/31)^2.5 * 2^frac) for every 5-bit code, evaluated at elaboration.
  function automatic lin_rom_t lin_rom(int frac);
    lin_rom_t    rom;
    logic [79:0] num;
    logic [79:0] quo;
    logic [79:0] rem;
    logic [79:0] x;
    logic [79:0] res;
    logic [79:0] b;
    for (int k = 0; k < 32; k++) begin
      num = 80'(k) * 80'(k) * 80'(k) * 80'(k) * 80'(k);
      num = num << (2 * frac);
      rem = '0;
      quo = '0;
      for (int i = 79; i >= 0; i--) begin
        rem = {rem[78:0], num[i]};
        quo = quo << 1;
        if (rem >= DEN5) begin
          rem    = rem - DEN5;
          quo[0] = 1'b1;
        end
      end
      x   = quo;
      res = '0;
      b   = 80'(1) << 50;
      for (int i = 0; i < 26; i++) begin
        if (x >= res + b) begin
          x   = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      rom[k] = res[LIN_W_MAX-1:0];
    end
    return rom;
  endfunction

  // Reduction of an 8-bit level to 5 bits with rounding, capped at 31.
  function automatic five_rom_t five_rom();
    five_rom_t rom;
    int        q;
    for (int v = 0; v < 256; v++) begin
      q = (v * 63 + 255) / 510;
      if (q > 31) begin
        q = 31;
      end
      rom[v] = 5'(q);
    end
    return rom;
  endfunction

  localparam five_rom_t FIVE_ROM = five_rom();

endpackage

`default_nettype wire

// ===== design/lccr555_lin.sv =====
// ----------------------------------------------------------------------------
// lccr555_lin
// Per-channel linearisation table followed by the brightness gain.
// ----------------------------------------------------------------------------
`default_nettype none

module lccr555_lin #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic [1:0]           load_i,
  input  logic [14:0]          color_i,
  input  logic [15:0]          luminance_i,
  output logic [FRAC_BITS-1:0] lin_o [3]
);

  localparam lccr555_pkg::lin_rom_t LIN_ROM = lccr555_pkg::lin_rom(FRAC_BITS);

  logic [FRAC_BITS:0]    raw_q [3];
  logic [FRAC_BITS+16:0] prod  [3];
  logic [FRAC_BITS-1:0]  lin_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = (FRAC_BITS+17)'(raw_q[c]) * (FRAC_BITS+17)'(luminance_i);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (load_i[0]) begin
        raw_q[c] <= LIN_ROM[color_i[5*c +: 5]][FRAC_BITS:0];
      end
      if (load_i[1]) begin
        // The gain is below one, so the top bit of the product is always clear.
        lin_q[c] <= prod[c][FRAC_BITS+15:16];
      end
    end
  end

  assign lin_o = lin_q;

endmodule

`default_nettype wire

// ===== design/lccr555_mix.sv =====
// ----------------------------------------------------------------------------
// lccr555_mix
// 3x3 colour mixing matrix with the negative sums clamped to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lccr555_mix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic [1:0]            load_i,
  input  logic [FRAC_BITS-1:0]  lin_i [3],
  output logic [FRAC_BITS+14:0] sum_o [3]
);

  logic signed [FRAC_BITS+16:0] prod_q [3][3];
  logic signed [FRAC_BITS+18:0] acc    [3];
  logic        [FRAC_BITS+14:0] sum_q  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = (FRAC_BITS+19)'(prod_q[c][0]) + (FRAC_BITS+19)'(prod_q[c][1])
             + (FRAC_BITS+19)'(prod_q[c][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (load_i[0]) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[c][j] <= $signed({1'b0, lin_i[j]}) * lccr555_pkg::MIX_COEF[c][j];
        end
      end
      if (load_i[1]) begin
        sum_q[c] <= acc[c][FRAC_BITS+18] ? '0 : acc[c][FRAC_BITS+14:0];
      end
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ===== design/lccr555_gamma.sv =====
// ----------------------------------------------------------------------------
// lccr555_gamma
// Scaling to the 8-bit range and a three-stage pipelined square root.
// ----------------------------------------------------------------------------
`default_nettype none

module lccr555_gamma #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic [4:0]            load_i,
  input  logic [FRAC_BITS+14:0] sum_i [3],
  output logic [8:0]            v8_o  [3]
);

  localparam int XW = lccr555_pkg::ISQ_W;

  typedef struct packed {
    logic [XW-1:0] rem;
    logic [XW-1:0] res;
  } sq_t;

  // Three digits of the bitwise square root, starting at digit pair "first".
  function automatic sq_t sq_steps(sq_t s, int first);
    sq_t         o;
    logic [XW:0] b;
    logic [XW:0] trial;
    o = s;
    for (int j = 0; j < 3; j++) begin
      b     = (XW+1)'(1) << (XW - 1 - 2 * (first + j));
      trial = {1'b0, o.res} + b;
      if ({1'b0, o.rem} >= trial) begin
        o.rem = XW'({1'b0, o.rem} - trial);
        o.res = XW'(({1'b0, o.res} >> 1) + b);
      end else begin
        o.res = o.res >> 1;
      end
    end
    return o;
  endfunction

  logic [FRAC_BITS+30:0] t1_q  [3];
  logic [FRAC_BITS+14:0] s_q   [3];
  logic [FRAC_BITS+30:0] scl   [3];
  logic [XW-1:0]         x_q   [3];
  sq_t                   sq_q  [3][3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scl[c] = t1_q[c] + (FRAC_BITS+31)'(s_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (load_i[0]) begin
        // sum * 65025 as sum * 65536 - sum * 512 + sum; the last term follows.
        t1_q[c] <= {sum_i[c], 16'b0} - {7'b0, sum_i[c], 9'b0};
        s_q[c]  <= sum_i[c];
      end
      if (load_i[1]) begin
        x_q[c] <= scl[c][FRAC_BITS+30:FRAC_BITS+14];
      end
      if (load_i[2]) begin
        sq_q[c][0] <= sq_steps('{rem: x_q[c], res: '0}, 0);
      end
      if (load_i[3]) begin
        sq_q[c][1] <= sq_steps(sq_q[c][0], 3);
      end
      if (load_i[4]) begin
        sq_q[c][2] <= sq_steps(sq_q[c][1], 6);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v8_o[c] = sq_q[c][2].res[8:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/lcd_color_correction_rgb555.sv =====
// ----------------------------------------------------------------------------
// lcd_color_correction_rgb555: a ten-stage valid/ready chain, input to output,
// gives a throughput of one pixel per cycle while the output side keeps up.
// rst_ni clears the valid bits at once and loads the gain with about 0.93.
// ----------------------------------------------------------------------------
`default_nettype none

// Colour correction for RGB555 pixels as they come off a frame buffer.
//
// Each channel is first linearised through a 32-entry table worked out at
// elaboration, then scaled by the brightness gain. The three linear channels
// are mixed by a fixed 3x3 matrix, the result goes through a square root
// (display gamma of two), and each level is reduced back to five bits.
//
// Stage map:
//   0     linearisation table look-up
//   1     brightness gain multiply
//   2     nine matrix products
//   3     row sums with clamp at zero
//   4, 5  scaling by 65025 as shifts and adds, alignment to 17 bits
//   6..8  square root, three result bits per stage
//   9     clamp to 255, five-bit reduction and packing (output register)
//
// Every stage has its own valid bit. A stage takes new data whenever it is
// empty or the stage after it moves on, so bubbles are squeezed out and a
// stalled output does not block the input until the whole pipeline is full.
// A transaction on the input therefore completes every cycle while the
// output side keeps up.

module lcd_color_correction_rgb555 #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        luminance_we_i,
  input  logic [15:0] luminance_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] color_in

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] color_out
);

  localparam int NSTG = lccr555_pkg::NSTG;

  // Brightness gain register; the user must write it only while the pipeline is idle, the block does not check.
  logic [15:0] lum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lum_q <= lccr555_pkg::LUM_RESET;
    end else if (luminance_we_i) begin
      lum_q <= luminance_i;
    end
  end

  // Valid bits and the load chain. load[i] is high when stage i may take a
  // new value: it is empty, or its contents move on in this cycle.
  logic [NSTG-1:0] valid_q;
  logic [NSTG:0]   load;

  always_comb begin
    load[NSTG] = m_axis_tready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      load[i] = !valid_q[i] || load[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (load[i]) begin
          valid_q[i] <= (i == 0) ? s_axis_tvalid : valid_q[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign s_axis_tready = load[0];

  // Datapath.
  logic [FRAC_BITS-1:0]  lin   [3];
  logic [FRAC_BITS+14:0] sum   [3];
  logic [8:0]            v8    [3];
  logic [7:0]            lvl   [3];
  logic [15:0]           out_q;

  lccr555_lin #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lin (
    .clk_i       (clk_i),
    .load_i      (load[1:0]),
    .color_i     (s_axis_tdata[14:0]),
    .luminance_i (lum_q),
    .lin_o       (lin)
  );

  lccr555_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk_i  (clk_i),
    .load_i (load[3:2]),
    .lin_i  (lin),
    .sum_o  (sum)
  );

  lccr555_gamma #(
    .FRAC_BITS (FRAC_BITS)
  ) u_gamma (
    .clk_i  (clk_i),
    .load_i (load[8:4]),
    .sum_i  (sum),
    .v8_o   (v8)
  );

  // The root can reach 264 for the brightest reds, hence the clamp to 255.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lvl[c] = v8[c][8] ? 8'hFF : v8[c][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[NSTG-1]) begin
      out_q <= {1'b1,
                lccr555_pkg::FIVE_ROM[lvl[2]],
                lccr555_pkg::FIVE_ROM[lvl[1]],
                lccr555_pkg::FIVE_ROM[lvl[0]]};
    end
  end

  assign m_axis_tvalid = valid_q[NSTG-1];
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// ===== design/lccr555_checker.sv =====
// ----------------------------------------------------------------------------
// lccr555_checker
// Port-level checks for the colour corrector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lcd_color_correction_rgb555_assert.svh"

module lccr555_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Every corrected pixel carries the top bit set.
  `LCCR_ASSERT_IMP(a_top_bit, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[15])

  // The input side only stalls when the pipeline is full behind a held output.
  `LCCR_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // A result that is not taken stays put.
  `LCCR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // No result can appear in the cycle after reset.
  `LCCR_ASSERT_ALL(a_reset_empty, clk_i, !rst_ni, !m_axis_tvalid)

endmodule

bind lcd_color_correction_rgb555 lccr555_checker u_lccr555_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== sim/lcd_color_correction_rgb555_checker.sv =====
// ----------------------------------------------------------------------------
// Pixel checker for the RGB555 LCD colour corrector
// Watches both stream sides and the brightness write port, works out the
// corrected pixel for every input transaction and compares each output
// transaction with the oldest pixel still owed.
// ----------------------------------------------------------------------------

module lcd_color_correction_rgb555_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        luminance_we_i,
  input  logic [15:0] luminance_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] out_data_i,
  output int          pending_o,
  output int          mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] FIFTH_POWER_OF_31 = 64'd28629151;
  localparam logic [15:0] GAIN_AT_RESET     = 16'd60948;

  logic [15:0] gain_copy;
  logic [15:0] owed_pixels [$];

  initial begin
    pending_o    = 0;
    mismatches_o = 0;
  end

  // Floor of the square root, one result bit per pair of input bits.
  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] acc;
    logic [63:0] probe;
    logic [63:0] rest;
    rest  = x;
    acc   = '0;
    probe = 64'd1 << 62;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= acc + probe) begin
        rest = rest - (acc + probe);
        acc  = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe = probe >> 2;
    end
    return acc;
  endfunction

  // floor((code/31)^2.5 * 2^FRAC_BITS), via the root of (code/31)^5 scaled twice.
  function automatic logic [63:0] linear_level(input logic [4:0] code);
    logic [63:0] c64;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    c64 = 64'(code);
    num = c64 * c64 * c64 * c64 * c64;
    quo = num / FIFTH_POWER_OF_31;
    rem = num % FIFTH_POWER_OF_31;
    for (int i = 0; i < 2 * FRAC_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= FIFTH_POWER_OF_31) begin
        rem    = rem - FIFTH_POWER_OF_31;
        quo[0] = 1'b1;
      end
    end
    return root_floor(quo);
  endfunction

  // Mixing matrix in Q2.14, row is the output channel.
  function automatic int mix_weight(input int row, input int col);
    case (row * 3 + col)
      0:       return 13107;
      1:       return 4506;
      2:       return -1229;
      3:       return 2212;
      4:       return 10486;
      5:       return 3686;
      6:       return 3195;
      7:       return 2540;
      default: return 10650;
    endcase
  endfunction

  function automatic logic [15:0] corrected_pixel(input logic [15:0] pix,
                                                  input logic [15:0] gain);
    logic [63:0] lin [3];
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] sum;
    logic [63:0] v8;
    logic [63:0] v5;
    logic [15:0] packed_pix;
    int          w;
    packed_pix = 16'h8000;
    for (int c = 0; c < 3; c++) begin
      lin[c] = (linear_level(pix[5*c +: 5]) * 64'(gain)) >> 16;
    end
    for (int r = 0; r < 3; r++) begin
      pos = '0;
      neg = '0;
      for (int j = 0; j < 3; j++) begin
        w = mix_weight(r, j);
        if (w >= 0) pos = pos + 64'(w) * lin[j];
        else        neg = neg + 64'(-w) * lin[j];
      end
      sum = (neg > pos) ? 64'd0 : pos - neg;
      v8  = root_floor((sum * 64'd65025) >> (FRAC_BITS + 14));
      if (v8 > 64'd255) v8 = 64'd255;
      v5 = (v8 * 64'd63 + 64'd255) / 64'd510;
      if (v5 > 64'd31) v5 = 64'd31;
      packed_pix[5*r +: 5] = v5[4:0];
    end
    return packed_pix;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] owed;
    if (!rst_ni) begin
      owed_pixels.delete();
      gain_copy <= GAIN_AT_RESET;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_pixels.size() == 0) begin
          $error("color_out: no pixel expected, got %h", out_data_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          owed = owed_pixels.pop_front();
          if (out_data_i !== owed) begin
            $error("color_out mismatch: expected %h, actual %h", owed, out_data_i);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        owed_pixels.push_back(corrected_pixel(in_data_i, gain_copy));
      end
      if (luminance_we_i) gain_copy <= luminance_i;
      pending_o <= owed_pixels.size();
    end
  end

endmodule

// ===== sim/lcd_color_correction_rgb555_tb.sv =====
// ----------------------------------------------------------------------------
// Regression bench for lcd_color_correction_rgb555
// Streams directed and random RGB555 pixels through the corrector under a
// range of brightness settings, with random idling on both stream sides,
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------

module lcd_color_correction_rgb555_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound on the whole run, counted in clock cycles.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_PIXELS  = 120;
  localparam int DRAIN_CYCLES  = 2 * lccr555_pkg::NSTG;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        luminance_we_i = 1'b0;
  logic [15:0] luminance_i    = '0;
  logic        s_tvalid       = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata        = '0;
  logic        m_tvalid;
  logic        m_tready       = 1'b0;
  logic [15:0] m_tdata;

  int pending;
  int mismatches;
  int cycles;
  int pixels_sent   = 0;
  int gain_settings = 1;
  int gap_odds      = 0;
  int stall_odds    = 0;

  lcd_color_correction_rgb555 #(
    .FRAC_BITS(16)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .luminance_we_i (luminance_we_i),
    .luminance_i    (luminance_i),
    .s_axis_tvalid  (s_tvalid),
    .s_axis_tready  (s_tready),
    .s_axis_tdata   (s_tdata),
    .m_axis_tvalid  (m_tvalid),
    .m_axis_tready  (m_tready),
    .m_axis_tdata   (m_tdata)
  );

  lcd_color_correction_rgb555_checker #(
    .FRAC_BITS(16)
  ) colour_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .luminance_we_i (luminance_we_i),
    .luminance_i    (luminance_i),
    .in_valid_i     (s_tvalid),
    .in_ready_i     (s_tready),
    .in_data_i      (s_tdata),
    .out_valid_i    (m_tvalid),
    .out_ready_i    (m_tready),
    .out_data_i     (m_tdata),
    .pending_o      (pending),
    .mismatches_o   (mismatches)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: if the run has not reached its verdict by now, something hangs.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("lcd_color_correction_rgb555 regression: fail");
    $finish;
  end

  // Output side. The receiver stalls in bursts of random length; the odds are
  // set per stretch of the run, and a stall odds of zero keeps it always ready.
  initial begin
    @(posedge clk_i);
    forever begin
      if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Presents one pixel and holds it until the transaction completes. The valid
  // stays high across back-to-back pixels, so it is only ever raised here.
  task automatic push_pixel(input logic [15:0] pix);
    if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk_i); while (!s_tready);
    pixels_sent++;
  endtask

  // Lets every owed pixel come out, then waits longer still so that the
  // pipeline is certainly empty before the brightness register is touched.
  // The first edge gives the checker time to count the last transaction.
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [15:0] gain);
    luminance_we_i <= 1'b1;
    luminance_i    <= gain;
    @(posedge clk_i);
    luminance_we_i <= 1'b0;
    gain_settings++;
  endtask

  // Random pixel. Most of the time each channel is drawn from black, full
  // scale or a random code, so that the clamps and the corners of the matrix
  // are hit often; the rest are plain random words. Bit 15 is always random.
  function automatic logic [15:0] random_pixel();
    logic [15:0] pix;
    pix = 16'($urandom());
    if ($urandom_range(0, 3) != 0) begin
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(0, 3))
          0:       pix[5*c +: 5] = 5'd0;
          1:       pix[5*c +: 5] = 5'd31;
          default: pix[5*c +: 5] = 5'($urandom());
        endcase
      end
    end
    return pix;
  endfunction

  // One brightness setting: a run of random pixels in which, unless quiet, the
  // idling odds are redrawn every 40 pixels so that stretches without idling occur.
  task automatic random_phase(input int count, input bit quiet);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        if (quiet) begin
          gap_odds   = 0;
          stall_odds = 0;
        end else begin
          case ($urandom_range(0, 2))
            0:       gap_odds = 0;
            1:       gap_odds = 10;
            default: gap_odds = 35;
          endcase
          case ($urandom_range(0, 2))
            0:       stall_odds = 0;
            1:       stall_odds = 15;
            default: stall_odds = 40;
          endcase
        end
      end
      push_pixel(random_pixel());
    end
    drain_pipeline();
  endtask

  logic [15:0] directed_pixels [16] = '{
    16'h0000,  // black
    16'hFFFF,  // white with the ignored top bit set
    16'h7FFF,  // white with the top bit clear
    16'h8000,  // black with only the ignored top bit set
    16'h001F,  // pure red
    16'h03E0,  // pure green
    16'h7C00,  // pure blue, which drives the red sum below zero
    16'hFC00,  // pure blue again, top bit set
    16'h0421,  // lowest code on every channel
    16'h0001,  // lowest red alone
    16'h0400,  // lowest blue alone
    16'h4210,  // mid grey
    16'h3DEF,  // just under mid grey
    16'h5555,  // alternating bits
    16'hAAAA,  // the other alternation
    16'h7FE0   // cyan, no red at all
  };

  initial begin
    // Reset is held low at the start and never asserted again.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels at the gain loaded by reset, with light idling.
    gap_odds   = 20;
    stall_odds = 20;
    foreach (directed_pixels[i]) push_pixel(directed_pixels[i]);
    drain_pipeline();

    // Zero gain turns every pixel black with the top bit set.
    write_gain(16'd0);
    push_pixel(16'hFFFF);
    random_phase(PHASE_PIXELS, 1'b0);

    // Full-scale gain, then the smallest non-zero gain and one half.
    write_gain(16'hFFFF);
    foreach (directed_pixels[i]) begin
      if (i < 4) push_pixel(directed_pixels[i]);
    end
    random_phase(PHASE_PIXELS, 1'b0);
    write_gain(16'd1);
    random_phase(PHASE_PIXELS, 1'b0);
    write_gain(16'h8000);
    random_phase(PHASE_PIXELS, 1'b0);

    // Random gains for the rest; the last setting runs with no idling at all.
    write_gain(16'($urandom()));
    random_phase(PHASE_PIXELS, 1'b0);
    write_gain(16'($urandom()));
    random_phase(PHASE_PIXELS, 1'b0);
    write_gain(16'($urandom()));
    random_phase(PHASE_PIXELS, 1'b1);

    $display("Covered %0d pixels under %0d brightness settings, zero and full scale among them.",
             pixels_sent, gain_settings);
    $display("Both stream sides idled in random bursts except in the final setting.");
    if (mismatches == 0 && pending == 0) begin
      $display("lcd_color_correction_rgb555 regression: pass");
    end else begin
      $display("lcd_color_correction_rgb555 regression: fail");
    end
    $finish;
  end

endmodule
